// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the mixer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked at every rising edge outside reset
`define QSM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked at every rising edge outside reset
`define QSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);
`else
`define QSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define QSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/qsm_pkg.sv =====
`timescale 1ns / 1ps
package qsm_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_COUNT        = 24;

	// datapath widths
	localparam int SYM_W   = 4;
	localparam int FREQ_W  = 24;
	localparam int PHASE_W = 32;
	localparam int XY_W    = 32;
	localparam int Z_W     = 34;
	localparam int TRIG_W  = 18;
	localparam int LVL_W   = 3;
	localparam int OUT_W   = 20;
	localparam int FRAC_DROP = 14;

	// cordic start value, gain compensation in q2.28
	localparam logic signed [XY_W-1:0] GAIN_Q28 = 32'sd163008219;
	localparam logic signed [XY_W-1:0] ROUND_HALF = 32'sd8192;

	// atan(2^-i) in q0.32 turns
	localparam logic [PHASE_W-1:0] ATAN_TURNS [ATAN_COUNT] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	// gray codes of the four levels
	localparam logic [1:0] GRAY_M3 = 2'b00;
	localparam logic [1:0] GRAY_M1 = 2'b01;
	localparam logic [1:0] GRAY_P1 = 2'b11;
	localparam logic [1:0] GRAY_P3 = 2'b10;

	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0]  z_t;
	typedef logic signed [LVL_W-1:0] lvl_t;

	// per-word data riding along the rotator
	typedef struct packed {
		lvl_t lvl_i;
		lvl_t lvl_q;
		logic flip;
		logic last;
	} side_t;

	function automatic lvl_t gray_level(input logic [1:0] bits);
		lvl_t lvl;
		case (bits)
			GRAY_M3: lvl = -3'sd3;
			GRAY_M1: lvl = -3'sd1;
			GRAY_P1: lvl = 3'sd1;
			GRAY_P3: lvl = 3'sd3;
			default: lvl = 3'sd0;
		endcase
		return lvl;
	endfunction

endpackage

// ===== rtl/core/qam16_subcarrier_mixer_unit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// 16-qam gray mapper and subcarrier mixer. A word is taken at every rising edge
// where start is high; busy never rises, so one word per clock is sustained.
// Each word comes out with done high for one cycle after passing a register for
// the phase multiply, one per rotator stage, one for rounding and one for the
// mix. Words come out in order and the receiver cannot stall them, so it must
// take a word in every cycle that done is high.
module qam16_subcarrier_mixer_unit #(
	parameter int CORDIC_STAGES = qsm_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [qsm_pkg::SYM_W-1:0]           symbol,
	input  logic [qsm_pkg::FREQ_W-1:0]          freq_hz,
	input  logic [qsm_pkg::PHASE_W-1:0]         time_point,
	input  logic                                end_of_subcarrier,
	output logic                                done,
	output logic signed [qsm_pkg::OUT_W-1:0]    sample_real,
	output logic signed [qsm_pkg::OUT_W-1:0]    sample_imag,
	output logic                                last_sample
);
	import qsm_pkg::*;

	localparam int LAT = CORDIC_STAGES + 3;

	logic                         accept;
	logic [PHASE_W-1:0]           phase_d;
	logic                         v_s1;
	logic [PHASE_W-1:0]           phase_s1;
	side_t                        side_s1;
	logic                         flip;
	logic [PHASE_W-1:0]           phase_fold;
	z_t                           cord_z;
	side_t                        cord_side;
	logic                         cord_v;
	xy_t                          cord_x;
	xy_t                          cord_y;
	side_t                        cord_out_side;
	xy_t                          x_rnd;
	xy_t                          y_rnd;
	logic signed [TRIG_W-1:0]     cos_r;
	logic signed [TRIG_W-1:0]     sin_r;
	logic                         v_s2;
	logic signed [TRIG_W-1:0]     cos_s2;
	logic signed [TRIG_W-1:0]     sin_s2;
	side_t                        side_s2;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// phase in turns: low word of frequency times time
	assign phase_d = PHASE_W'(freq_hz) * time_point;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1      <= phase_d;
		side_s1.lvl_i <= gray_level(symbol[3:2]);
		side_s1.lvl_q <= gray_level(symbol[1:0]);
		side_s1.flip  <= 1'b0;
		side_s1.last  <= end_of_subcarrier;
	end

	// quadrant fold into [-1/4, 1/4) turn, result negated later
	always_comb begin
		flip       = phase_s1[PHASE_W-1] ^ phase_s1[PHASE_W-2];
		phase_fold = {phase_s1[PHASE_W-1] ^ flip, phase_s1[PHASE_W-2:0]};
		cord_z     = z_t'(signed'(phase_fold));
		cord_side      = side_s1;
		cord_side.flip = flip;
	end

	qsm_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_z     (cord_z),
		.in_side  (cord_side),
		.out_valid(cord_v),
		.out_x    (cord_x),
		.out_y    (cord_y),
		.out_side (cord_out_side)
	);

	// round q2.28 to q1.14 and undo the fold
	assign x_rnd = (cord_x + ROUND_HALF) >>> FRAC_DROP;
	assign y_rnd = (cord_y + ROUND_HALF) >>> FRAC_DROP;
	assign cos_r = x_rnd[TRIG_W-1:0];
	assign sin_r = y_rnd[TRIG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= cord_v;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= cord_out_side;
		if (cord_out_side.flip) begin
			cos_s2 <= -cos_r;
			sin_s2 <= -sin_r;
		end else begin
			cos_s2 <= cos_r;
			sin_s2 <= sin_r;
		end
	end

	// complex mix of the constellation point, output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sample_real <= OUT_W'(side_s2.lvl_i) * OUT_W'(cos_s2)
			- OUT_W'(side_s2.lvl_q) * OUT_W'(sin_s2);
		sample_imag <= OUT_W'(side_s2.lvl_i) * OUT_W'(sin_s2)
			+ OUT_W'(side_s2.lvl_q) * OUT_W'(cos_s2);
		last_sample <= side_s2.last;
	end

	// checks on latency, word count and value range
	`QSM_ASSERT_IMP(a_latency, clk, arst_n, accept, ##(LAT) done, "word did not come out on time")
	`QSM_ASSERT_IMP(a_no_extra, clk, arst_n, done, $past(accept, LAT), "word out without a word in")
	`QSM_ASSERT_IMP(a_trig_range, clk, arst_n, v_s2, (cos_s2 <= 18'sd16400 && cos_s2 >= -18'sd16400 && sin_s2 <= 18'sd16400 && sin_s2 >= -18'sd16400), "rotator output out of range")
	`QSM_ASSERT_IMP(a_out_range, clk, arst_n, done, ((sample_real[OUT_W-1:17] == 3'b000 || sample_real[OUT_W-1:17] == 3'b111) && (sample_imag[OUT_W-1:17] == 3'b000 || sample_imag[OUT_W-1:17] == 3'b111)), "mixed sample out of range")

endmodule

// ===== rtl/core/qsm_cordic.sv =====
`timescale 1ns / 1ps
module qsm_cordic #(
	parameter int STAGES = qsm_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  qsm_pkg::z_t   in_z,
	input  qsm_pkg::side_t in_side,
	output logic          out_valid,
	output qsm_pkg::xy_t  out_x,
	output qsm_pkg::xy_t  out_y,
	output qsm_pkg::side_t out_side
);
	import qsm_pkg::*;

	logic  v_s    [STAGES+1];
	xy_t   x_s    [STAGES+1];
	xy_t   y_s    [STAGES+1];
	z_t    z_s    [STAGES+1];
	side_t side_s [STAGES+1];

	// stage zero: gain-compensated unit vector on the x axis
	assign v_s[0]    = in_valid;
	assign x_s[0]    = GAIN_Q28;
	assign y_s[0]    = '0;
	assign z_s[0]    = in_z;
	assign side_s[0] = in_side;

	// one micro-rotation per register stage
	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		z_t atan_z;
		assign atan_z = z_t'({{(Z_W-PHASE_W){1'b0}}, ATAN_TURNS[g]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			side_s[g+1] <= side_s[g];
			if (!z_s[g][Z_W-1]) begin
				x_s[g+1] <= x_s[g] - (y_s[g] >>> g);
				y_s[g+1] <= y_s[g] + (x_s[g] >>> g);
				z_s[g+1] <= z_s[g] - atan_z;
			end else begin
				x_s[g+1] <= x_s[g] + (y_s[g] >>> g);
				y_s[g+1] <= y_s[g] - (x_s[g] >>> g);
				z_s[g+1] <= z_s[g] + atan_z;
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign out_x     = x_s[STAGES];
	assign out_y     = y_s[STAGES];
	assign out_side  = side_s[STAGES];

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

	localparam int STAGES     = qsm_pkg::CORDIC_STAGES_DEF;
	localparam int ANGLE_CNT  = 24;
	localparam int LATENCY    = STAGES + 3;
	localparam int RAND_WORDS = 1300;
	localparam int CALM_TAIL  = 150;
	localparam longint START_GAIN = 64'sd163008219;
	localparam longint HALF_LSB   = 64'sd8192;

	// rotation angle of each stage, atan(2^-i) in q0.32 turns
	localparam logic [31:0] ROT_ANGLE [ANGLE_CNT] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic [qsm_pkg::SYM_W-1:0]   sym;
		logic [qsm_pkg::FREQ_W-1:0]  freq;
		logic [qsm_pkg::PHASE_W-1:0] tp;
		logic                        eos;
		logic                        drain;
	} tx_word_t;

	typedef struct packed {
		logic signed [qsm_pkg::OUT_W-1:0] re;
		logic signed [qsm_pkg::OUT_W-1:0] im;
		logic                             last;
	} mixed_sample_t;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic [qsm_pkg::SYM_W-1:0]           symbol = '0;
	logic [qsm_pkg::FREQ_W-1:0]          freq_hz = '0;
	logic [qsm_pkg::PHASE_W-1:0]         time_point = '0;
	logic                                end_of_subcarrier = 1'b0;
	logic                                done;
	logic signed [qsm_pkg::OUT_W-1:0]    sample_real;
	logic signed [qsm_pkg::OUT_W-1:0]    sample_imag;
	logic                                last_sample;

	tx_word_t      words_to_send [$];
	mixed_sample_t samples_due [$];
	tx_word_t      next_word;
	mixed_sample_t due_sample;
	int            gap_left = 0;
	int            bad_cnt = 0;

	qam16_subcarrier_mixer_unit #(
		.CORDIC_STAGES(STAGES)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.symbol           (symbol),
		.freq_hz          (freq_hz),
		.time_point       (time_point),
		.end_of_subcarrier(end_of_subcarrier),
		.done             (done),
		.sample_real      (sample_real),
		.sample_imag      (sample_imag),
		.last_sample      (last_sample)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// gray-coded 16-qam level of two bits
	function automatic longint qam_level(input logic [1:0] bits);
		longint lvl;
		case (bits)
			qsm_pkg::GRAY_M3: lvl = -3;
			qsm_pkg::GRAY_M1: lvl = -1;
			qsm_pkg::GRAY_P1: lvl = 1;
			default:          lvl = 3;
		endcase
		return lvl;
	endfunction

	// expected mixer output for one word
	function automatic mixed_sample_t mix_point(input tx_word_t w);
		logic [55:0]        prod;
		logic [31:0]        phase;
		logic [31:0]        folded;
		logic signed [31:0] folded_s;
		logic               flip;
		longint             x, y, z, xs, ys, re, im;
		mixed_sample_t      r;
		prod = 56'(w.freq) * 56'(w.tp);
		phase = prod[31:0];
		// second and third quadrants are turned by half a turn
		flip = phase[31] ^ phase[30];
		folded = flip ? phase + 32'h80000000 : phase;
		folded_s = folded;
		z = longint'(folded_s);
		x = START_GAIN;
		y = 0;
		for (int i = 0; i < STAGES && i < ANGLE_CNT; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(ROT_ANGLE[i]);
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(ROT_ANGLE[i]);
			end
		end
		x = (x + HALF_LSB) >>> 14;
		y = (y + HALF_LSB) >>> 14;
		if (flip) begin
			x = -x;
			y = -y;
		end
		re = qam_level(w.sym[3:2]) * x - qam_level(w.sym[1:0]) * y;
		im = qam_level(w.sym[3:2]) * y + qam_level(w.sym[1:0]) * x;
		r.re = re[19:0];
		r.im = im[19:0];
		r.last = w.eos;
		return r;
	endfunction

	task automatic report_bad(input string what, input int want_v, input int got_v);
		bad_cnt++;
		if (bad_cnt <= 10)
			$display("mismatch %s: expected %0d got %0d at %0t", what, want_v, got_v, $time);
	endtask

	// driver: one word per clock unless idling or draining
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				samples_due.insert(samples_due.size(), mix_point({symbol, freq_hz,
					time_point, end_of_subcarrier, 1'b0}));
			if (start && busy) begin
				// word not taken yet, hold it
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (words_to_send.size() != 0 &&
					!(words_to_send[0].drain && samples_due.size() != 0)) begin
				next_word = words_to_send.pop_front();
				start <= 1'b1;
				symbol <= next_word.sym;
				freq_hz <= next_word.freq;
				time_point <= next_word.tp;
				end_of_subcarrier <= next_word.eos;
				if (words_to_send.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
					gap_left <= int'($urandom_range(1, 15));
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done word is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (samples_due.size() == 0) begin
				report_bad("unexpected word, real", 0, int'(sample_real));
			end else begin
				due_sample = samples_due.pop_front();
				if (sample_real !== due_sample.re)
					report_bad("sample_real", int'(due_sample.re), int'(sample_real));
				if (sample_imag !== due_sample.im)
					report_bad("sample_imag", int'(due_sample.im), int'(sample_imag));
				if (last_sample !== due_sample.last)
					report_bad("last_sample", int'(due_sample.last), int'(last_sample));
			end
		end
	end

	// stimulus and end of run
	initial begin
		tx_word_t w;
		logic [31:0] edge_phase [8];
		edge_phase = '{32'h00000000, 32'h20000000, 32'h3FFFFFFF, 32'h40000000,
			32'h7FFFFFFF, 32'h80000000, 32'hBFFFFFFF, 32'hC0000000};
		// every symbol with extreme frequency and time
		for (int i = 0; i < 16; i++) begin
			w.sym = 4'(i);
			w.freq = i[0] ? 24'hFFFFFF : 24'h000000;
			w.tp = i[1] ? 32'hFFFFFFFF : 32'h00000000;
			w.eos = i[3];
			w.drain = 1'b0;
			words_to_send.insert(words_to_send.size(), w);
		end
		// phases on and next to the quadrant borders
		for (int i = 0; i < 8; i++) begin
			w.sym = 4'($urandom_range(0, 15));
			w.freq = 24'd1;
			w.tp = edge_phase[i];
			w.eos = i[0];
			w.drain = 1'b0;
			words_to_send.insert(words_to_send.size(), w);
		end
		w.tp = 32'hFFFFFFFF;
		words_to_send.insert(words_to_send.size(), w);
		// random words, a drain ahead of the first and in the middle
		for (int n = 0; n < RAND_WORDS; n++) begin
			w.sym = 4'($urandom_range(0, 15));
			case ($urandom_range(0, 3))
				0: w.freq = 24'd1;
				1: w.freq = 24'($urandom_range(0, 1000));
				default: w.freq = 24'($urandom);
			endcase
			w.tp = $urandom;
			w.eos = 1'($urandom_range(0, 1));
			w.drain = (n == 0) || (n == RAND_WORDS / 2);
			words_to_send.insert(words_to_send.size(), w);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (words_to_send.size() != 0 || start)
			@(posedge clk);
		while (samples_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (bad_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/qsm_pkg.sv
rtl/core/qsm_cordic.sv
rtl/core/qam16_subcarrier_mixer_unit.sv
tb/sv/tb_top.sv
